[rtl/tal_pkg.sv]
package tal_pkg;

  localparam int PAGE_BYTES  = 8192;
  localparam int MAX_COLUMNS = 32;
  localparam int ADDR_W      = $clog2(PAGE_BYTES);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CNT_W       = 6;
  localparam logic [15:0] HDR_OFFSET = 16'd22;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_DESC  = 2'd1,
    OP_PARSE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_HDR,
    U_HDRW,
    U_COL,
    U_FIX,
    U_V0,
    U_V1,
    U_V2
  } upc_e;

  typedef enum logic [1:0] {
    A_HDR,
    A_POS,
    A_POS1,
    A_VPOS
  } addr_sel_e;

  typedef enum logic [2:0] {
    P_HOLD,
    P_RDATA,
    P_PAD,
    P_FIX,
    P_VAR
  } pos_sel_e;

  typedef enum logic [1:0] {
    E_NONE,
    E_FIX,
    E_VAR
  } emit_e;

  typedef enum logic [1:0] {
    I_HOLD,
    I_CLR,
    I_INC
  } idx_op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_CNT0,
    C_VAR,
    C_LAST
  } cond_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    pos_sel_e  pos_sel;
    logic      lo_ld;
    emit_e     emit;
    idx_op_e   idx_op;
    cond_e     cond;
    upc_e      t_true;
    upc_e      t_false;
  } uword_t;

  // The control store: one word per step of the column walk.
  function automatic uword_t ucode(upc_e upc);
    uword_t w;
    w = '{A_POS, P_HOLD, 1'b0, E_NONE, I_HOLD, C_ALWAYS, U_IDLE, U_IDLE};
    case (upc)
      U_IDLE: w = '{A_HDR,  P_HOLD,  1'b0, E_NONE, I_HOLD, C_START,  U_HDR,  U_IDLE};
      U_HDR:  w = '{A_HDR,  P_HOLD,  1'b0, E_NONE, I_HOLD, C_ALWAYS, U_HDRW, U_HDRW};
      U_HDRW: w = '{A_POS,  P_RDATA, 1'b0, E_NONE, I_CLR,  C_CNT0,   U_IDLE, U_COL};
      U_COL:  w = '{A_POS,  P_HOLD,  1'b0, E_NONE, I_HOLD, C_VAR,    U_V0,   U_FIX};
      U_FIX:  w = '{A_POS,  P_FIX,   1'b0, E_FIX,  I_INC,  C_LAST,   U_IDLE, U_COL};
      U_V0:   w = '{A_VPOS, P_PAD,   1'b0, E_NONE, I_HOLD, C_ALWAYS, U_V1,   U_V1};
      U_V1:   w = '{A_POS1, P_HOLD,  1'b1, E_NONE, I_HOLD, C_ALWAYS, U_V2,   U_V2};
      U_V2:   w = '{A_POS1, P_VAR,   1'b0, E_VAR,  I_INC,  C_LAST,   U_IDLE, U_COL};
      default: w = '{A_POS, P_HOLD,  1'b0, E_NONE, I_HOLD, C_ALWAYS, U_IDLE, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/tuple_attribute_locator.sv]
// Parses heap tuples of one page held in an internal 8 KiB byte store. Load requests
// (tuser op 0 writes a page byte, op 1 a column descriptor) are taken only while no
// parse is in progress. A parse request (op 2) yields one result per column, up to
// min(column_count, 32), with tlast on the final column; column_count zero gives no
// result. A parse reads the header size, then per column a descriptor step and either
// a fixed-length step or padding, low-byte and high-byte steps for a variable-length
// column, paced by the single read port of the page store and the microcode sequencer;
// a result held back by m_axis_tready stretches this. New requests are taken once the
// walk has finished, even while the last result still waits in the output register.
module tuple_attribute_locator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tal_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // page_address, byte_value, column_number, column_length, align_mask,
  // tuple_offset, tuple_length, tuple_slot, zero fill
  input  logic [tal_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_out, column_index, attribute_offset, attribute_length, start_out,
  // length_out, zero fill
  output logic [tal_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);

  localparam logic [15:0] HDR_POS = tal_pkg::HDR_OFFSET;

  logic [tal_pkg::ADDR_W-1:0] in_page_addr;
  logic [7:0]                 in_byte;
  logic [4:0]                 in_col;
  logic [15:0]                in_len;
  logic [2:0]                 in_align;
  logic [12:0]                in_toff;
  logic [13:0]                in_tlen;
  logic [8:0]                 in_slot;
  tal_pkg::op_e               in_op;

  assign in_page_addr = s_axis_tdata[tal_pkg::ADDR_W-1:0];
  assign in_byte      = s_axis_tdata[20:13];
  assign in_col       = s_axis_tdata[25:21];
  assign in_len       = s_axis_tdata[41:26];
  assign in_align     = s_axis_tdata[44:42];
  assign in_toff      = s_axis_tdata[57:45];
  assign in_tlen      = s_axis_tdata[71:58];
  assign in_slot      = s_axis_tdata[80:72];
  assign in_op        = tal_pkg::op_e'(s_axis_tuser);

  logic [tal_pkg::CNT_W-1:0] col_count_q;
  logic [7:0]                page_mem [tal_pkg::PAGE_BYTES];
  logic [7:0]                rdata_q;
  logic [15:0]               col_len_mem [tal_pkg::MAX_COLUMNS];
  logic [2:0]                col_align_mem [tal_pkg::MAX_COLUMNS];

  tal_pkg::upc_e             upc_q, upc_d;
  tal_pkg::uword_t           uw;
  logic [15:0]               pos_q, pos_d;
  logic [tal_pkg::COL_W-1:0] idx_q, idx_d;
  logic [7:0]                lo_q;
  logic [12:0]               toff_q;
  logic [13:0]               tlen_q;
  logic [8:0]                slot_q;

  logic                      out_valid_q;
  logic [tal_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                      out_last_q, out_last_d;

  logic                      accept, start, out_free, stall, cond, emit_go;
  logic [tal_pkg::CNT_W-1:0] ncol;
  logic                      last_col, desc_var;
  logic [15:0]               dlen, al, aligned, pad_pos, vword, total, meta;
  logic [15:0]               aoff, alen, rd_pos;
  logic [tal_pkg::ADDR_W-1:0] rd_addr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (upc_q == tal_pkg::U_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (in_op == tal_pkg::OP_PARSE);

  assign ncol = (col_count_q > tal_pkg::CNT_W'(tal_pkg::MAX_COLUMNS)) ?
                tal_pkg::CNT_W'(tal_pkg::MAX_COLUMNS) : col_count_q;
  assign last_col = (tal_pkg::CNT_W'(idx_q) + tal_pkg::CNT_W'(1)) == ncol;

  assign dlen     = col_len_mem[idx_q];
  assign al       = {13'd0, col_align_mem[idx_q]};
  assign desc_var = dlen[15] || (dlen == 16'd0);
  assign aligned  = (pos_q + al) & ~al;
  assign pad_pos  = (rdata_q == 8'd0) ? aligned : pos_q;

  assign vword = {rdata_q, lo_q};
  always_comb begin
    if (vword[0]) begin
      total = {9'd0, vword[7:1]};
      meta  = 16'd1;
    end else begin
      total = {2'd0, vword[15:2]};
      meta  = 16'd4;
    end
  end

  assign uw       = tal_pkg::ucode(upc_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign stall    = (uw.emit != tal_pkg::E_NONE) && !out_free;
  assign emit_go  = (uw.emit != tal_pkg::E_NONE) && out_free;

  always_comb begin
    case (uw.addr_sel)
      tal_pkg::A_HDR:  rd_pos = HDR_POS;
      tal_pkg::A_POS:  rd_pos = pos_q;
      tal_pkg::A_POS1: rd_pos = pos_q + 16'd1;
      tal_pkg::A_VPOS: rd_pos = pad_pos;
      default:         rd_pos = pos_q;
    endcase
  end

  always_comb begin
    logic [15:0] base;
    logic [15:0] sum;
    base = (uw.addr_sel == tal_pkg::A_HDR && upc_q == tal_pkg::U_IDLE) ?
           {3'd0, in_toff} : {3'd0, toff_q};
    sum  = base + rd_pos;
    rd_addr = sum[tal_pkg::ADDR_W-1:0];
  end

  always_comb begin
    case (uw.cond)
      tal_pkg::C_ALWAYS: cond = 1'b1;
      tal_pkg::C_START:  cond = start;
      tal_pkg::C_CNT0:   cond = (ncol == '0);
      tal_pkg::C_VAR:    cond = desc_var;
      tal_pkg::C_LAST:   cond = last_col;
      default:           cond = 1'b1;
    endcase
  end

  always_comb begin
    upc_d      = upc_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    aoff       = aligned;
    alen       = dlen;
    if (uw.emit == tal_pkg::E_VAR) begin
      aoff = pos_q + meta;
      alen = total - meta;
    end
    if (!stall) begin
      upc_d = cond ? uw.t_true : uw.t_false;
      case (uw.pos_sel)
        tal_pkg::P_HOLD:  pos_d = pos_q;
        tal_pkg::P_RDATA: pos_d = {8'd0, rdata_q};
        tal_pkg::P_PAD:   pos_d = pad_pos;
        tal_pkg::P_FIX:   pos_d = aligned + dlen;
        tal_pkg::P_VAR:   pos_d = pos_q + total;
        default:          pos_d = pos_q;
      endcase
      case (uw.idx_op)
        tal_pkg::I_HOLD: idx_d = idx_q;
        tal_pkg::I_CLR:  idx_d = '0;
        tal_pkg::I_INC:  idx_d = idx_q + tal_pkg::COL_W'(1);
        default:         idx_d = idx_q;
      endcase
    end
    if (emit_go) begin
      out_data_d = {7'd0, tlen_q, toff_q, alen, aoff, 5'(idx_q), slot_q};
      out_last_d = last_col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_op == tal_pkg::OP_BYTE) begin
      page_mem[in_page_addr] <= in_byte;
    end
    rdata_q <= page_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_op == tal_pkg::OP_DESC &&
        {1'b0, in_col} < 6'(tal_pkg::MAX_COLUMNS)) begin
      col_len_mem[in_col[tal_pkg::COL_W-1:0]]   <= in_len;
      col_align_mem[in_col[tal_pkg::COL_W-1:0]] <= in_align;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (uw.lo_ld) begin
      lo_q <= rdata_q;
    end
    if (start) begin
      toff_q <= in_toff;
      tlen_q <= in_tlen;
      slot_q <= in_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= tal_pkg::U_IDLE;
      col_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_valid_i) begin
        col_count_q <= cfg_data_i;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
